>>> src/particle_slice_and_grid_deposit_defines.svh
// ----------------------------------------------------------------------------
// Particle slice and grid deposit: assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_SLICE_AND_GRID_DEPOSIT_DEFINES_SVH
`define PARTICLE_SLICE_AND_GRID_DEPOSIT_DEFINES_SVH

// Same-cycle implication.
`define PSGD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psgd assertion failed");

// Next-cycle implication.
`define PSGD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psgd assertion failed");

`endif

>>> src/psgd_pkg.sv
// ----------------------------------------------------------------------------
// psgd_pkg
// Sizes, codes and types of the particle slice and grid deposit block.
// ----------------------------------------------------------------------------
package psgd_pkg;

	localparam int SLICES      = 256;
	localparam int ENERGY_BINS = 64;
	localparam int GRID_CELLS  = 64;
	localparam int NODES       = GRID_CELLS + 1;

	localparam int SL_DEPTH   = SLICES;
	localparam int HIST_DEPTH = SLICES * ENERGY_BINS;
	localparam int GRID_DEPTH = NODES * NODES;
	localparam int SL_AW      = $clog2(SL_DEPTH);
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int GR_AW      = $clog2(GRID_DEPTH);
	localparam int GI_W       = $clog2(NODES);

	localparam int CLR_LEN0 = (SL_DEPTH > HIST_DEPTH) ? SL_DEPTH : HIST_DEPTH;
	localparam int CLR_LEN  = (CLR_LEN0 > GRID_DEPTH) ? CLR_LEN0 : GRID_DEPTH;
	localparam int CLR_AW   = $clog2(CLR_LEN);

	localparam logic [2:0] CMD_DEPOSIT    = 3'd0;
	localparam logic [2:0] CMD_READ_SLICE = 3'd1;
	localparam logic [2:0] CMD_READ_BIN   = 3'd2;
	localparam logic [2:0] CMD_READ_CELL  = 3'd3;
	localparam logic [2:0] CMD_READ_TOTAL = 3'd4;
	localparam logic [2:0] CMD_CLEAR      = 3'd5;

	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_OOR = 2'd1;
	localparam logic [1:0] STAT_SAT = 2'd2;

	localparam logic [2:0] CFG_CENTER_SLICE = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_X     = 3'd1;
	localparam logic [2:0] CFG_ORIGIN_Y     = 3'd2;
	localparam logic [2:0] CFG_GRID_INV     = 3'd3;
	localparam logic [2:0] CFG_ENERGY_MIN   = 3'd4;
	localparam logic [2:0] CFG_ENERGY_INV   = 3'd5;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDWAIT,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_GCHK,
		ST_CW,
		ST_CM,
		ST_CWR,
		ST_RESP
	} state_t;

endpackage

>>> src/psgd_stream_if.sv
// ----------------------------------------------------------------------------
// psgd_stream_if
// Valid/ready channels for deposit commands and their results.
// ----------------------------------------------------------------------------
interface psgd_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [7:0]         slice;
	logic signed [31:0] x_pos;
	logic signed [31:0] y_pos;
	logic [31:0]        energy;
	logic [31:0]        weight;
	logic [5:0]         bin;
	logic [6:0]         cell_i;
	logic [6:0]         cell_j;

	modport source (output valid, cmd, slice, x_pos, y_pos, energy, weight, bin, cell_i,
		cell_j, input ready);
	modport sink (input valid, cmd, slice, x_pos, y_pos, energy, weight, bin, cell_i,
		cell_j, output ready);
endinterface

interface psgd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [47:0] value_a;
	logic [63:0] value_b;

	modport source (output valid, status, value_a, value_b, input ready);
	modport sink (input valid, status, value_a, value_b, output ready);
endinterface

>>> src/psgd_ram.sv
// ----------------------------------------------------------------------------
// psgd_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module psgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/particle_slice_and_grid_deposit.sv
// ----------------------------------------------------------------------------
// particle_slice_and_grid_deposit
// Macro-particle diagnostics: slice sums, energy histogram, cloud-in-cell grid.
// ----------------------------------------------------------------------------
// The block takes one command at a time and returns exactly one result for it.
// A memory read passes RDWAIT, which captures the data, then RESP. A deposit
// steps through MUL0 to MUL3 and GCHK; one on the centre slice that lands on
// the grid then updates the four grid nodes one after another through the
// single shared 34x32 multiplier and the grid memory port (CW, CM, CWR per
// node). A clear command, and every reset, runs a clearing pass over CLR_LEN
// entries (16384 at the default sizes) that zeroes every memory one entry per
// cycle; no command is taken during the pass, configuration writes are. A
// result waiting on the output register does not keep the next command out.
module particle_slice_and_grid_deposit
	import psgd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	psgd_in_if.sink     items_in,
	psgd_out_if.source  results_out
);

`include "particle_slice_and_grid_deposit_defines.svh"

	// Configuration registers.
	logic [7:0]         center_q;
	logic signed [31:0] ox_q;
	logic signed [31:0] oy_q;
	logic [31:0]        ginv_q;
	logic [31:0]        emin_q;
	logic [31:0]        einv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= 8'd128;
			ox_q     <= '0;
			oy_q     <= '0;
			ginv_q   <= 32'd65536;
			emin_q   <= '0;
			einv_q   <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTER_SLICE: center_q <= cfg_data[7:0];
				CFG_ORIGIN_X:     ox_q     <= cfg_data;
				CFG_ORIGIN_Y:     oy_q     <= cfg_data;
				CFG_GRID_INV:     ginv_q   <= cfg_data;
				CFG_ENERGY_MIN:   emin_q   <= cfg_data;
				CFG_ENERGY_INV:   einv_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state.
	state_t             state_q, state_d;
	logic [CLR_AW-1:0]  clr_q;
	logic               clr_resp_q;
	logic [1:0]         corner_q;
	logic               out_valid_q;

	// Latched command.
	logic [2:0]         cmd_q;
	logic [7:0]         slice_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic [31:0]        e_q;
	logic [31:0]        w_q;

	// Working registers.
	logic               bad_q, sat_q, off_q, hist_ok_q;
	logic [47:0]        va_q;
	logic [63:0]        vb_q;
	logic [47:0]        total_q;
	logic [63:0]        gx_q;
	logic [GI_W-1:0]    i_q, j_q;
	logic [15:0]        fx_q, fy_q;
	logic [65:0]        prod_q;
	logic [1:0]         out_status_q;
	logic [47:0]        out_va_q;
	logic [63:0]        out_vb_q;

	// Memory ports.
	logic               sl_we, sl_re, hi_we, hi_re, gr_we, gr_re;
	logic [SL_AW-1:0]   sl_waddr, sl_raddr;
	logic [HIST_AW-1:0] hi_waddr, hi_raddr;
	logic [GR_AW-1:0]   gr_waddr, gr_raddr;
	logic [111:0]       sl_wdata, sl_rdata;
	logic [23:0]        hi_wdata, hi_rdata;
	logic [47:0]        gr_wdata, gr_rdata;

	psgd_ram #(.WIDTH(112), .DEPTH(SL_DEPTH)) u_slice_ram (
		.clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
		.re(sl_re), .raddr(sl_raddr), .rdata(sl_rdata)
	);

	psgd_ram #(.WIDTH(24), .DEPTH(HIST_DEPTH)) u_hist_ram (
		.clk(clk), .we(hi_we), .waddr(hi_waddr), .wdata(hi_wdata),
		.re(hi_re), .raddr(hi_raddr), .rdata(hi_rdata)
	);

	psgd_ram #(.WIDTH(48), .DEPTH(GRID_DEPTH)) u_grid_ram (
		.clk(clk), .we(gr_we), .waddr(gr_waddr), .wdata(gr_wdata),
		.re(gr_re), .raddr(gr_raddr), .rdata(gr_rdata)
	);

	// Shared multiplier, result registered every cycle.
	logic [33:0] mul_a;
	logic [31:0] mul_b;

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Datapath terms.
	logic               accept, out_free, clr_last;
	logic               in_sl_ok, in_bin_ok, in_cell_ok;
	logic [48:0]        charge_sum, total_sum, grid_sum;
	logic [64:0]        esum_sum;
	logic               hist_full;
	logic signed [32:0] dx, dy;
	logic               off_x, off_y, bin_ok;
	logic [16:0]        wx, wy;
	logic [GI_W-1:0]    ci_n, cj_n;

	assign accept     = items_in.valid && items_in.ready;
	assign out_free   = !out_valid_q || results_out.ready;
	assign clr_last   = (clr_q == CLR_AW'(CLR_LEN - 1));
	assign in_sl_ok   = (32'(items_in.slice) < 32'(SLICES));
	assign in_bin_ok  = in_sl_ok && (32'(items_in.bin) < 32'(ENERGY_BINS));
	assign in_cell_ok = (32'(items_in.cell_i) <= 32'(GRID_CELLS)) &&
		(32'(items_in.cell_j) <= 32'(GRID_CELLS));

	assign charge_sum = {1'b0, sl_rdata[47:0]} + 49'(w_q);
	assign esum_sum   = {1'b0, sl_rdata[111:48]} + {1'b0, prod_q[63:0]};
	assign total_sum  = {1'b0, total_q} + 49'(w_q);
	assign hist_full  = (hi_rdata == 24'hFFFFFF);
	assign grid_sum   = {1'b0, gr_rdata} + 49'(prod_q[65:32]);

	assign dx = {x_q[31], x_q} - {ox_q[31], ox_q};
	assign dy = {y_q[31], y_q} - {oy_q[31], oy_q};

	// A negative offset is off the grid unless the inverse step is zero.
	assign off_x = (dx[32] && ginv_q != '0) || (gx_q[63:32] >= 32'(GRID_CELLS));
	assign off_y = (dy[32] && ginv_q != '0) || (prod_q[63:32] >= 32'(GRID_CELLS));
	assign bin_ok = (e_q >= emin_q) && (prod_q[63:32] < 32'(ENERGY_BINS - 1));

	assign wx = corner_q[1] ? {1'b0, fx_q} : 17'(17'd65536 - 17'(fx_q));
	assign wy = corner_q[0] ? {1'b0, fy_q} : 17'(17'd65536 - 17'(fy_q));
	assign ci_n = GI_W'(i_q + GI_W'(corner_q[1]));
	assign cj_n = GI_W'(j_q + GI_W'(corner_q[0]));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_last) state_d = clr_resp_q ? ST_RESP : ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (items_in.cmd)
						CMD_DEPOSIT:    state_d = in_sl_ok ? ST_MUL0 : ST_RESP;
						CMD_READ_SLICE: state_d = in_sl_ok ? ST_RDWAIT : ST_RESP;
						CMD_READ_BIN:   state_d = in_bin_ok ? ST_RDWAIT : ST_RESP;
						CMD_READ_CELL:  state_d = in_cell_ok ? ST_RDWAIT : ST_RESP;
						CMD_CLEAR:      state_d = ST_CLEAR;
						default:        state_d = ST_RESP;
					endcase
				end
			end
			ST_RDWAIT: state_d = ST_RESP;
			ST_MUL0:   state_d = ST_MUL1;
			ST_MUL1:   state_d = ST_MUL2;
			ST_MUL2:   state_d = ST_MUL3;
			ST_MUL3:   state_d = ST_GCHK;
			ST_GCHK: begin
				if (slice_q == center_q && !off_x && !off_y) begin
					state_d = ST_CW;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_CW:     state_d = ST_CM;
			ST_CM:     state_d = ST_CWR;
			ST_CWR:    state_d = (corner_q == 2'd3) ? ST_RESP : ST_CW;
			ST_RESP:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake, memory ports, multiplier operands.
	always_comb begin
		items_in.ready = (state_q == ST_IDLE);
		sl_we = 1'b0; sl_waddr = SL_AW'(slice_q);
		sl_wdata = {esum_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF
			: esum_sum[63:0], charge_sum[48] ? 48'hFFFF_FFFF_FFFF : charge_sum[47:0]};
		sl_re = 1'b0; sl_raddr = SL_AW'(items_in.slice);
		hi_we = 1'b0;
		hi_waddr = HIST_AW'(HIST_AW'(slice_q) * HIST_AW'(ENERGY_BINS) +
			HIST_AW'(gx_q[63:32]));
		hi_wdata = hist_full ? hi_rdata : 24'(hi_rdata + 24'd1);
		hi_re = 1'b0;
		hi_raddr = HIST_AW'(HIST_AW'(items_in.slice) * HIST_AW'(ENERGY_BINS) +
			HIST_AW'(items_in.bin));
		gr_we = 1'b0;
		gr_waddr = GR_AW'(GR_AW'(ci_n) * GR_AW'(NODES) + GR_AW'(cj_n));
		gr_wdata = grid_sum[48] ? 48'hFFFF_FFFF_FFFF : grid_sum[47:0];
		gr_re = 1'b0;
		gr_raddr = GR_AW'(GR_AW'(items_in.cell_i) * GR_AW'(NODES) +
			GR_AW'(items_in.cell_j));
		mul_a = 34'(e_q);
		mul_b = w_q;
		case (state_q)
			ST_CLEAR: begin
				sl_we = (32'(clr_q) < 32'(SL_DEPTH));
				sl_waddr = SL_AW'(clr_q);
				sl_wdata = '0;
				hi_we = (32'(clr_q) < 32'(HIST_DEPTH));
				hi_waddr = HIST_AW'(clr_q);
				hi_wdata = '0;
				gr_we = (32'(clr_q) < 32'(GRID_DEPTH));
				gr_waddr = GR_AW'(clr_q);
				gr_wdata = '0;
			end
			ST_IDLE: begin
				sl_re = accept && (items_in.cmd == CMD_DEPOSIT ||
					items_in.cmd == CMD_READ_SLICE) && in_sl_ok;
				hi_re = accept && items_in.cmd == CMD_READ_BIN && in_bin_ok;
				gr_re = accept && items_in.cmd == CMD_READ_CELL && in_cell_ok;
			end
			ST_MUL1: begin
				sl_we = 1'b1;
				mul_a = (e_q >= emin_q) ? 34'(e_q - emin_q) : '0;
				mul_b = einv_q;
			end
			ST_MUL2: begin
				hi_re = bin_ok;
				hi_raddr = HIST_AW'(HIST_AW'(slice_q) * HIST_AW'(ENERGY_BINS) +
					HIST_AW'(prod_q[63:32]));
				mul_a = dx[32] ? '0 : 34'(dx[31:0]);
				mul_b = ginv_q;
			end
			ST_MUL3: begin
				hi_we = hist_ok_q;
				mul_a = dy[32] ? '0 : 34'(dy[31:0]);
				mul_b = ginv_q;
			end
			ST_CW: begin
				gr_re = 1'b1;
				gr_raddr = gr_waddr;
				mul_a = 34'(wx);
				mul_b = 32'(wy);
			end
			ST_CM: begin
				mul_a = prod_q[33:0];
				mul_b = w_q;
			end
			ST_CWR: gr_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			clr_resp_q  <= 1'b0;
			corner_q    <= '0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_last ? '0 : CLR_AW'(clr_q + 1'b1);
			end
			if (accept) begin
				clr_resp_q <= (items_in.cmd == CMD_CLEAR);
				if (items_in.cmd == CMD_CLEAR) begin
					total_q <= '0;
				end
			end
			if (state_q == ST_MUL1) begin
				total_q <= total_sum[48] ? 48'hFFFF_FFFF_FFFF : total_sum[47:0];
			end
			if (state_q == ST_GCHK) begin
				corner_q <= '0;
			end else if (state_q == ST_CWR) begin
				corner_q <= 2'(corner_q + 2'd1);
			end
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q   <= items_in.cmd;
				slice_q <= items_in.slice;
				x_q     <= items_in.x_pos;
				y_q     <= items_in.y_pos;
				e_q     <= items_in.energy;
				w_q     <= items_in.weight;
				sat_q   <= 1'b0;
				off_q   <= 1'b0;
				va_q    <= (items_in.cmd == CMD_READ_TOTAL) ? total_q : '0;
				vb_q    <= '0;
				case (items_in.cmd)
					CMD_DEPOSIT:    bad_q <= !in_sl_ok;
					CMD_READ_SLICE: bad_q <= !in_sl_ok;
					CMD_READ_BIN:   bad_q <= !in_bin_ok;
					CMD_READ_CELL:  bad_q <= !in_cell_ok;
					CMD_READ_TOTAL: bad_q <= 1'b0;
					CMD_CLEAR:      bad_q <= 1'b0;
					default:        bad_q <= 1'b1;
				endcase
			end
			ST_RDWAIT: begin
				case (cmd_q)
					CMD_READ_SLICE: begin
						va_q <= sl_rdata[47:0];
						vb_q <= sl_rdata[111:48];
					end
					CMD_READ_BIN:  va_q <= 48'(hi_rdata);
					CMD_READ_CELL: va_q <= gr_rdata;
					default: ;
				endcase
			end
			ST_MUL1: sat_q <= sat_q || charge_sum[48] || esum_sum[64] || total_sum[48];
			ST_MUL2: begin
				hist_ok_q <= bin_ok;
				gx_q      <= prod_q[63:0];
			end
			ST_MUL3: begin
				gx_q <= prod_q[63:0];
				if (hist_ok_q && hist_full) begin
					sat_q <= 1'b1;
				end
			end
			ST_GCHK: begin
				off_q <= (slice_q == center_q) && (off_x || off_y);
				i_q   <= GI_W'(gx_q[63:32]);
				j_q   <= GI_W'(prod_q[63:32]);
				fx_q  <= gx_q[31:16];
				fy_q  <= prod_q[31:16];
			end
			ST_CWR: if (grid_sum[48]) sat_q <= 1'b1;
			ST_RESP: begin
				if (out_free) begin
					out_status_q <= (bad_q || off_q) ? STAT_OOR : (sat_q ? STAT_SAT : STAT_OK);
					out_va_q     <= va_q;
					out_vb_q     <= vb_q;
				end
			end
			default: ;
		endcase
	end

	// The histogram address in the MUL3 write uses the bin latched in gx_q at MUL2.

	assign results_out.valid   = out_valid_q;
	assign results_out.status  = out_status_q;
	assign results_out.value_a = out_va_q;
	assign results_out.value_b = out_vb_q;

	// No command is taken while the clearing pass runs.
	`PSGD_ASSERT_IMP(a_no_take_in_clear, state_q == ST_CLEAR, !items_in.ready)
	// A result is held back while the previous one has not been taken.
	`PSGD_ASSERT_NXT(a_resp_waits, state_q == ST_RESP && out_valid_q && !results_out.ready,
		state_q == ST_RESP)
	// The clearing pass ends on its last entry.
	`PSGD_ASSERT_NXT(a_clear_ends, state_q == ST_CLEAR && clr_last, state_q != ST_CLEAR)
	// The grid is written only within a corner sweep or the clearing pass.
	`PSGD_ASSERT_IMP(a_grid_write, gr_we, state_q == ST_CWR || state_q == ST_CLEAR)

endmodule

>>> test/particle_slice_and_grid_deposit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_slice_and_grid_deposit_tb
// Self-checking bench for the slice, histogram and grid deposit block.
// A behavioral predictor tracks every accumulator and the configuration. Each
// result transfer is compared with the oldest prediction, while both channels
// idle at random.
// ----------------------------------------------------------------------------
module particle_slice_and_grid_deposit_tb;
	import psgd_pkg::*;

	// Saturation limits of the accumulators.
	localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] MAX24 = 64'hFF_FFFF;
	// Settling wait after the last expected result has come back.
	localparam int DRAIN_CYCLES = 25;
	// The watchdog limit lies above a clearing pass, during which nothing is transferred.
	localparam int IDLE_LIMIT = 60000;

	typedef struct {
		logic [2:0]         cmd;
		logic [7:0]         slice;
		logic signed [31:0] x_pos;
		logic signed [31:0] y_pos;
		logic [31:0]        energy;
		logic [31:0]        weight;
		logic [5:0]         bin;
		logic [6:0]         cell_i;
		logic [6:0]         cell_j;
	} particle_cmd_t;

	typedef struct {
		logic [1:0]  status;
		logic [47:0] value_a;
		logic [63:0] value_b;
	} readout_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = CFG_CENTER_SLICE;
	logic [31:0] cfg_data = '0;

	psgd_in_if  items_in ();
	psgd_out_if results_out ();

	particle_slice_and_grid_deposit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.items_in    (items_in),
		.results_out (results_out)
	);

	always #2 clk = ~clk;

	// Predicted contents of every store in the block.
	logic [63:0] pred_slice_charge [SLICES];
	logic [63:0] pred_slice_energy [SLICES];
	logic [63:0] pred_hist [SLICES * ENERGY_BINS];
	logic [63:0] pred_grid [NODES * NODES];
	logic [63:0] pred_total;

	// Configuration as last written.
	logic [7:0]         center_slice;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic [31:0]        grid_inv;
	logic [31:0]        energy_min;
	logic [31:0]        energy_inv;

	readout_t expected_readouts [$];
	int       fail_count = 0;
	int       idle_cycles = 0;

	// Long receiver hold-off: the test bumps hold_seq, the receiver counts.
	int hold_seq = 0;
	int hold_len = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;
	bit rx_calm = 1'b0;
	bit tx_calm = 1'b0;

	function automatic bit clips(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] lim);
		return (a > lim) || (b > lim - a);
	endfunction

	function automatic void clear_stores();
		foreach (pred_slice_charge[k]) pred_slice_charge[k] = '0;
		foreach (pred_slice_energy[k]) pred_slice_energy[k] = '0;
		foreach (pred_hist[k]) pred_hist[k] = '0;
		foreach (pred_grid[k]) pred_grid[k] = '0;
		pred_total = '0;
	endfunction

	// Grid coordinate in Q32.32; returns 0 when the particle lies below the corner and the step is nonzero.
	function automatic bit grid_coord(input logic signed [31:0] pos,
		input logic signed [31:0] org, output logic [63:0] q);
		logic signed [63:0] d;
		d = {{32{pos[31]}}, pos};
		d = d - {{32{org[31]}}, org};
		q = '0;
		if (d < 0) return (grid_inv == 0);
		q = 64'(d) * {32'b0, grid_inv};
		return 1'b1;
	endfunction

	function automatic logic [1:0] predict_deposit(input particle_cmd_t c);
		logic        sat;
		logic        off;
		logic [63:0] e, w, sum, b, qx, qy, part;
		logic [63:0] wx [2];
		logic [63:0] wy [2];
		int          s, idx, gi, gj;
		sat = 1'b0;
		off = 1'b0;
		s = int'(c.slice);
		e = {32'b0, c.energy};
		w = {32'b0, c.weight};

		if (clips(pred_slice_charge[s], w, MAX48)) begin
			sat = 1'b1;
			pred_slice_charge[s] = MAX48;
		end else pred_slice_charge[s] = pred_slice_charge[s] + w;

		sum = pred_slice_energy[s] + e * w;
		if (sum < pred_slice_energy[s]) begin
			sat = 1'b1;
			sum = '1;
		end
		pred_slice_energy[s] = sum;

		if (clips(pred_total, w, MAX48)) begin
			sat = 1'b1;
			pred_total = MAX48;
		end else pred_total = pred_total + w;

		// Energies below the lower edge and in the top bin are dropped silently.
		if (c.energy >= energy_min) begin
			b = {32'b0, c.energy - energy_min} * {32'b0, energy_inv};
			b = b >> 32;
			if (b < ENERGY_BINS - 1) begin
				idx = s * ENERGY_BINS + int'(b);
				if (clips(pred_hist[idx], 64'd1, MAX24)) begin
					sat = 1'b1;
					pred_hist[idx] = MAX24;
				end else pred_hist[idx] = pred_hist[idx] + 1;
			end
		end

		if (c.slice == center_slice) begin
			if (grid_coord(c.x_pos, origin_x, qx) && grid_coord(c.y_pos, origin_y, qy)
				&& (qx >> 32) < GRID_CELLS && (qy >> 32) < GRID_CELLS) begin
				wx[1] = (qx >> 16) & 64'hFFFF;
				wy[1] = (qy >> 16) & 64'hFFFF;
				wx[0] = 64'd65536 - wx[1];
				wy[0] = 64'd65536 - wy[1];
				for (int a = 0; a < 2; a++) begin
					for (int bb = 0; bb < 2; bb++) begin
						// The product fits in 64 bits even for the heaviest particles.
						part = ((wx[a] * wy[bb]) * w) >> 32;
						gi = int'(qx >> 32) + a;
						gj = int'(qy >> 32) + bb;
						idx = gi * NODES + gj;
						if (clips(pred_grid[idx], part, MAX48)) begin
							sat = 1'b1;
							pred_grid[idx] = MAX48;
						end else pred_grid[idx] = pred_grid[idx] + part;
					end
				end
			end else off = 1'b1;
		end

		if (off) return STAT_OOR;
		return sat ? STAT_SAT : STAT_OK;
	endfunction

	function automatic readout_t predict_readout(input particle_cmd_t c);
		readout_t r;
		r.status = STAT_OK;
		r.value_a = '0;
		r.value_b = '0;
		case (c.cmd)
			CMD_DEPOSIT: r.status = predict_deposit(c);
			CMD_READ_SLICE: begin
				r.value_a = pred_slice_charge[c.slice][47:0];
				r.value_b = pred_slice_energy[c.slice];
			end
			CMD_READ_BIN: r.value_a = pred_hist[int'(c.slice) * ENERGY_BINS + int'(c.bin)][47:0];
			CMD_READ_CELL: begin
				if (c.cell_i <= GRID_CELLS && c.cell_j <= GRID_CELLS)
					r.value_a = pred_grid[int'(c.cell_i) * NODES + int'(c.cell_j)][47:0];
				else r.status = STAT_OOR;
			end
			CMD_READ_TOTAL: r.value_a = pred_total[47:0];
			CMD_CLEAR: clear_stores();
			default: r.status = STAT_OOR;
		endcase
		return r;
	endfunction

	function automatic particle_cmd_t make_cmd(input logic [2:0] cmd, input logic [7:0] slice,
		input logic [31:0] x, input logic [31:0] y, input logic [31:0] e, input logic [31:0] w,
		input logic [5:0] bin, input logic [6:0] ci, input logic [6:0] cj);
		particle_cmd_t c;
		c.cmd = cmd;
		c.slice = slice;
		c.x_pos = x;
		c.y_pos = y;
		c.energy = e;
		c.weight = w;
		c.bin = bin;
		c.cell_i = ci;
		c.cell_j = cj;
		return c;
	endfunction

	// A coordinate that lands on the grid for the current corner and step.
	function automatic logic [31:0] coord_on_grid(input logic signed [31:0] org);
		logic [63:0] span;
		span = (grid_inv == 0) ? 64'h7FFF_FFFF : ((64'd64 << 32) / {32'b0, grid_inv});
		if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
		return org + ($urandom % span[31:0]);
	endfunction

	function automatic particle_cmd_t random_cmd();
		particle_cmd_t c;
		logic [63:0]   espan;
		int            r;
		c = make_cmd(CMD_DEPOSIT, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom);
		r = $urandom_range(0, 99);
		if (r < 62) begin
			c.cmd = CMD_DEPOSIT;
			if ($urandom_range(0, 1)) c.slice = center_slice;
			if ($urandom_range(0, 9) < 8) begin
				c.x_pos = coord_on_grid(origin_x);
				c.y_pos = coord_on_grid(origin_y);
			end
			if ($urandom_range(0, 9) < 7) begin
				espan = (energy_inv == 0) ? 64'hFFFF_FFFF
					: ((64'd63 << 32) / {32'b0, energy_inv});
				if (espan > 64'hFFFF_FFFF) espan = 64'hFFFF_FFFF;
				c.energy = energy_min + 32'($urandom % (espan[31:0] + 32'd0 == 0 ? 1 : espan));
			end
			if ($urandom_range(0, 9) < 8) c.weight = $urandom_range(0, 32'h000F_FFFF);
		end else if (r < 70) begin
			c.cmd = CMD_READ_SLICE;
			if ($urandom_range(0, 1)) c.slice = center_slice;
		end else if (r < 80) begin
			c.cmd = CMD_READ_BIN;
			if ($urandom_range(0, 1)) c.slice = center_slice;
		end else if (r < 93) begin
			c.cmd = CMD_READ_CELL;
			if ($urandom_range(0, 9) < 8) begin
				c.cell_i = $urandom_range(0, GRID_CELLS);
				c.cell_j = $urandom_range(0, GRID_CELLS);
			end
		end else if (r < 98) c.cmd = CMD_READ_TOTAL;
		else c.cmd = $urandom_range(6, 7);
		return c;
	endfunction

	function automatic int pick_gap();
		int r;
		if (tx_calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Offer one command, wait for its transfer, then record its prediction.
	task automatic send_cmd(input particle_cmd_t c, input int gap);
		items_in.valid  <= 1'b1;
		items_in.cmd    <= c.cmd;
		items_in.slice  <= c.slice;
		items_in.x_pos  <= c.x_pos;
		items_in.y_pos  <= c.y_pos;
		items_in.energy <= c.energy;
		items_in.weight <= c.weight;
		items_in.bin    <= c.bin;
		items_in.cell_i <= c.cell_i;
		items_in.cell_j <= c.cell_j;
		do @(posedge clk); while (!items_in.ready);
		expected_readouts.push_back(predict_readout(c));
		if (gap > 0) begin
			items_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender until every result has come back and the block is idle.
	task automatic wait_idle();
		items_in.valid <= 1'b0;
		@(posedge clk);
		while (expected_readouts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [7:0] cs, input logic [31:0] ox,
		input logic [31:0] oy, input logic [31:0] gi, input logic [31:0] emin,
		input logic [31:0] ei);
		logic [31:0] vals [6];
		wait_idle();
		vals = '{{24'b0, cs}, ox, oy, gi, emin, ei};
		for (int k = 0; k < 6; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(k);
			cfg_data  <= vals[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		center_slice = cs;
		origin_x = ox;
		origin_y = oy;
		grid_inv = gi;
		energy_min = emin;
		energy_inv = ei;
	endtask

	task automatic run_random(input int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
			send_cmd(random_cmd(), pick_gap());
		end
	endtask

	// Reset contents, node and bin edges, the unfilled top bin, off-grid
	// particles, energy sum saturation, out-of-range reads and unknown codes.
	task automatic test_directed();
		send_cmd(make_cmd(CMD_READ_TOTAL, 0, 0, 0, 0, 0, 0, 0, 0), 0);
		send_cmd(make_cmd(CMD_READ_SLICE, 8'd128, 0, 0, 0, 0, 0, 0, 0), 1);
		send_cmd(make_cmd(CMD_DEPOSIT, 8'd128, 0, 0, 0, 32'h100, 0, 0, 0), 0);
		send_cmd(make_cmd(CMD_DEPOSIT, 8'd128, 32'h003F_8000, 32'h003F_FFFF,
			32'h003E_E666, 32'hFFFF_FFFF, 0, 0, 0), 0);
		send_cmd(make_cmd(CMD_DEPOSIT, 8'd128, 32'h0040_0000, 0, 32'h1_0000, 32'h200,
			0, 0, 0), 2);
		send_cmd(make_cmd(CMD_DEPOSIT, 8'd128, 0, 32'hFFFF_FFFF, 32'h1_0000, 32'h200,
			0, 0, 0), 0);
		send_cmd(make_cmd(CMD_DEPOSIT, 8'd3, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h003F_0000, 32'h100, 0, 0, 0), 0);
		send_cmd(make_cmd(CMD_DEPOSIT, 8'd3, 0, 0, 32'h003E_FFFF, 32'h100, 0, 0, 0), 0);
		send_cmd(make_cmd(CMD_DEPOSIT, 8'd255, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			0, 0, 0), 0);
		send_cmd(make_cmd(CMD_DEPOSIT, 8'd255, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			0, 0, 0), 3);
		send_cmd(make_cmd(CMD_READ_SLICE, 8'd255, 0, 0, 0, 0, 0, 0, 0), 0);
		send_cmd(make_cmd(CMD_READ_BIN, 8'd3, 0, 0, 0, 0, 6'd62, 0, 0), 0);
		send_cmd(make_cmd(CMD_READ_BIN, 8'd3, 0, 0, 0, 0, 6'd63, 0, 0), 0);
		send_cmd(make_cmd(CMD_READ_BIN, 8'd128, 0, 0, 0, 0, 6'd0, 0, 0), 0);
		send_cmd(make_cmd(CMD_READ_CELL, 0, 0, 0, 0, 0, 0, 7'd0, 7'd0), 0);
		send_cmd(make_cmd(CMD_READ_CELL, 0, 0, 0, 0, 0, 0, 7'd64, 7'd64), 0);
		send_cmd(make_cmd(CMD_READ_CELL, 0, 0, 0, 0, 0, 0, 7'd63, 7'd64), 0);
		send_cmd(make_cmd(CMD_READ_CELL, 0, 0, 0, 0, 0, 0, 7'd65, 7'd0), 0);
		send_cmd(make_cmd(CMD_READ_CELL, 0, 0, 0, 0, 0, 0, 7'd0, 7'd127), 0);
		send_cmd(make_cmd(CMD_READ_TOTAL, 0, 0, 0, 0, 0, 0, 0, 0), 0);
		send_cmd(make_cmd(3'd6, 8'hFF, '1, '1, '1, '1, '1, '1, '1), 0);
		send_cmd(make_cmd(3'd7, 8'hFF, '1, '1, '1, '1, '1, '1, '1), 0);
		send_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0);
		send_cmd(make_cmd(CMD_READ_TOTAL, 0, 0, 0, 0, 0, 0, 0, 0), 0);
	endtask

	// Walk through extreme and ordinary settings, including zero steps.
	task automatic test_config_sweep();
		write_config(8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1);
		run_random(50);
		write_config(8'd255, 32'hFFF0_0000, 32'h0010_0000, 32'hFFFF_FFFF, 32'd0,
			32'hFFFF_FFFF);
		run_random(50);
		write_config(8'd17, 32'h0000_8000, 32'hFFFF_0000, 32'd0, 32'h0002_0000, 32'd0);
		run_random(50);
		write_config(8'd200, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000,
			32'h8000_0000, 32'h0000_4000);
		run_random(50);
		write_config(8'd64, 32'hFFE0_0000, 32'hFFE0_0000, 32'h0000_8000, 32'h0001_0000,
			32'h0004_0000);
		run_random(60);
	endtask

	// The receiver holds off long enough that the block fills and stalls input.
	task automatic test_backpressure();
		write_config(8'd128, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000);
		hold_len = 600;
		hold_seq = hold_seq + 1;
		for (int k = 0; k < 40; k++) send_cmd(random_cmd(), 0);
	endtask

	// Long random run with clears that each wait for a quiet block first.
	task automatic test_random_mix();
		write_config(8'd90, 32'hFFF8_0000, 32'h0001_0000, 32'h0001_8000, 32'h0000_8000,
			32'h0001_0000);
		run_random(300);
		wait_idle();
		send_cmd(make_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom), 0);
		run_random(300);
		wait_idle();
		send_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0);
		run_random(220);
	endtask

	// Receiver: random stalls, calm stretches, and the requested long hold-off.
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			results_out.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			results_out.ready <= 1'b0;
		end else begin
			results_out.ready <= 1'b1;
			if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
			if (!rx_calm && $urandom_range(0, 99) < 20)
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(1, 3);
		end
	end

	// Check each result transfer against the oldest prediction; the watchdog
	// restarts whenever either channel completes a transfer.
	always @(posedge clk) begin
		readout_t exp_r;
		if (results_out.valid && results_out.ready) begin
			if (expected_readouts.size() == 0) begin
				$display("%0t: unexpected result status %h value_a %h value_b %h", $time,
					results_out.status, results_out.value_a, results_out.value_b);
				fail_count = fail_count + 1;
			end else begin
				exp_r = expected_readouts.pop_front();
				if (results_out.status !== exp_r.status) begin
					$display("%0t: status expected %h actual %h", $time, exp_r.status,
						results_out.status);
					fail_count = fail_count + 1;
				end
				if (results_out.value_a !== exp_r.value_a) begin
					$display("%0t: value_a expected %h actual %h", $time, exp_r.value_a,
						results_out.value_a);
					fail_count = fail_count + 1;
				end
				if (results_out.value_b !== exp_r.value_b) begin
					$display("%0t: value_b expected %h actual %h", $time, exp_r.value_b,
						results_out.value_b);
					fail_count = fail_count + 1;
				end
			end
		end
		if ((results_out.valid && results_out.ready) || (items_in.valid && items_in.ready))
			idle_cycles = 0;
		else idle_cycles = idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
			$display("particle_slice_and_grid_deposit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		items_in.valid    = 1'b0;
		items_in.cmd      = CMD_READ_TOTAL;
		items_in.slice    = '0;
		items_in.x_pos    = '0;
		items_in.y_pos    = '0;
		items_in.energy   = '0;
		items_in.weight   = '0;
		items_in.bin      = '0;
		items_in.cell_i   = '0;
		items_in.cell_j   = '0;
		results_out.ready = 1'b0;
		center_slice = 8'd128;
		origin_x = '0;
		origin_y = '0;
		grid_inv = 32'h0001_0000;
		energy_min = '0;
		energy_inv = 32'h0001_0000;
		clear_stores();

		// Reset is released once; the block then runs its clearing pass and
		// simply holds ready low until the pass is over.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_sweep();
		test_backpressure();
		test_random_mix();
		wait_idle();

		if (fail_count == 0) begin
			$display("particle_slice_and_grid_deposit_tb OK");
		end else begin
			$display("particle_slice_and_grid_deposit_tb NOT OK");
		end
		$finish;
	end

endmodule
